// ===== sv/shabs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shabs_pkg
// Shared types and constants for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package shabs_pkg;

   localparam int WordWidth = 32;
   localparam int ByteWidth = 8;
   localparam int NumRounds = 64;
   localparam int NumWords  = 8;
   localparam int SchedLen  = 16;

   localparam logic [ByteWidth-1:0] PadMarker = 8'h80;

   // working variables a..h of one compression
   typedef struct packed {
      logic [WordWidth-1:0] a;
      logic [WordWidth-1:0] b;
      logic [WordWidth-1:0] c;
      logic [WordWidth-1:0] d;
      logic [WordWidth-1:0] e;
      logic [WordWidth-1:0] f;
      logic [WordWidth-1:0] g;
      logic [WordWidth-1:0] h;
   } wv_type;

   // schedule taps the round unit needs
   typedef struct packed {
      logic [WordWidth-1:0] w0;
      logic [WordWidth-1:0] w1;
      logic [WordWidth-1:0] w9;
      logic [WordWidth-1:0] w14;
   } taps_type;

   localparam logic [WordWidth-1:0] InitHash [0:NumWords-1] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WordWidth-1:0] RoundK [0:NumRounds-1] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage
`default_nettype wire

// ===== sv/shabs_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shabs_round
// One SHA-256 round plus the next message schedule word.
// ----------------------------------------------------------------------------
module shabs_round (
   input  wire  shabs_pkg::wv_type                  wv_cur,
   input  wire  shabs_pkg::taps_type                taps,
   input  wire  logic [shabs_pkg::WordWidth-1:0]    k_word,
   output shabs_pkg::wv_type                        wv_next,
   output logic [shabs_pkg::WordWidth-1:0]          w_new
);

   function automatic logic [31:0] rotr(input logic [31:0] v, input int amt);
      rotr = (v >> amt) | (v << (32 - amt));
   endfunction

   logic [31:0] big_s0;
   logic [31:0] big_s1;
   logic [31:0] sml_s0;
   logic [31:0] sml_s1;
   logic [31:0] choose;
   logic [31:0] major;
   logic [31:0] t1;
   logic [31:0] t2;

   always_comb begin
      big_s0 = rotr(wv_cur.a, 2) ^ rotr(wv_cur.a, 13) ^ rotr(wv_cur.a, 22);
      big_s1 = rotr(wv_cur.e, 6) ^ rotr(wv_cur.e, 11) ^ rotr(wv_cur.e, 25);
      choose = (wv_cur.e & wv_cur.f) ^ (~wv_cur.e & wv_cur.g);
      major  = (wv_cur.a & wv_cur.b) ^ (wv_cur.a & wv_cur.c) ^ (wv_cur.b & wv_cur.c);
      t1     = wv_cur.h + big_s1 + choose + k_word + taps.w0;
      t2     = big_s0 + major;

      wv_next.h = wv_cur.g;
      wv_next.g = wv_cur.f;
      wv_next.f = wv_cur.e;
      wv_next.e = wv_cur.d + t1;
      wv_next.d = wv_cur.c;
      wv_next.c = wv_cur.b;
      wv_next.b = wv_cur.a;
      wv_next.a = t1 + t2;

      // W[t+16] from the window
      sml_s0 = rotr(taps.w1, 7) ^ rotr(taps.w1, 18) ^ (taps.w1 >> 3);
      sml_s1 = rotr(taps.w14, 17) ^ rotr(taps.w14, 19) ^ (taps.w14 >> 10);
      w_new  = sml_s1 + taps.w9 + sml_s0 + taps.w0;
   end

endmodule
`default_nettype wire

// ===== sv/sha256_byte_stream_hasher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// SHA-256 over a byte stream, one shared round unit, digest out as 8 words.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_): tdata = message byte, tuser = byte present,
//    tlast = end of message. A request with tuser low carries no byte; with
//    tlast high it closes the message (an empty message is allowed).
//  - Response channel (rsp_): eight responses per message, h0 first;
//    tdata = digest word, tuser = word number, tlast on word 7.
//  - Bytes are taken one per cycle, while req_tready is high, into a 16-word
//    window. The 64th byte of a block starts the compression: the single
//    round unit steps through all 64 rounds, then the result is folded into
//    the chaining value, and req_tready is low all the while.
//  - At end of message the padding (0x80, zeros, 64-bit bit length) is fed
//    through the same byte path, one byte per cycle outside the compressions,
//    followed by one or two compressions (two when 56 or more bytes sit in the last block). The
//    first digest word appears in the cycle after the final fold.
//  - The block takes no request while the digest is out; a stalled receiver
//    simply holds the current word. After word 7 the chaining value and the
//    byte count return to their initial values.
//  - Reset (synchronous, active high) returns to idle with the initial hash
//    words and a zero byte count.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   input  wire  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire  logic        req_tuser,   // [0] byte_present
   input  wire  logic        req_tlast,   // end_of_message
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   output logic [31:0]       rsp_tdata,   // [31:0] digest_word
   output logic [2:0]        rsp_tuser,   // [2:0] word_number
   output logic              rsp_tlast    // last_word
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_FOLD  = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   localparam logic [5:0] LastRound = 6'd63;
   localparam logic [5:0] LastByte  = 6'd63;
   localparam logic [2:0] LastWord  = 3'd7;

   // control
   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;       // bytes in the current block
   logic [5:0]  round_ff, round_in;
   logic [2:0]  word_ff, word_in;
   logic [63:0] count_ff, count_in;     // message bytes, wraps mod 2^64
   logic        pad_active_ff, pad_active_in;
   logic        mark_ff, mark_in;       // 0x80 already placed
   logic        need_extra_ff, need_extra_in;
   logic        last_block_ff, last_block_in;
   logic [31:0] chain_ff [0:shabs_pkg::NumWords-1];
   logic [31:0] chain_in [0:shabs_pkg::NumWords-1];

   // payload
   logic [31:0]        win_ff [0:shabs_pkg::SchedLen-1];
   logic [31:0]        win_in [0:shabs_pkg::SchedLen-1];
   shabs_pkg::wv_type  wv_ff, wv_in;

   shabs_pkg::taps_type taps;
   shabs_pkg::wv_type   wv_next;
   logic [31:0]         w_new;
   logic [63:0]         bit_len;
   logic                push;
   logic [7:0]          push_byte;
   logic                req_fire;
   logic                rsp_fire;

   assign taps.w0  = win_ff[0];
   assign taps.w1  = win_ff[1];
   assign taps.w9  = win_ff[9];
   assign taps.w14 = win_ff[14];

   shabs_round u_round (
      .wv_cur  (wv_ff),
      .taps    (taps),
      .k_word  (shabs_pkg::RoundK[round_ff]),
      .wv_next (wv_next),
      .w_new   (w_new)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = chain_ff[0];
   assign rsp_tuser  = word_ff;
   assign rsp_tlast  = (word_ff == LastWord);
   assign bit_len    = {count_ff[60:0], 3'b000};

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      round_in      = round_ff;
      word_in       = word_ff;
      count_in      = count_ff;
      pad_active_in = pad_active_ff;
      mark_in       = mark_ff;
      need_extra_in = need_extra_ff;
      last_block_in = last_block_ff;
      chain_in      = chain_ff;
      win_in        = win_ff;
      wv_in         = wv_ff;
      push          = 1'b0;
      push_byte     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  push      = 1'b1;
                  push_byte = req_tdata;
                  count_in  = count_ff + 64'd1;
               end
               if (req_tlast) begin
                  pad_active_in = 1'b1;
                  mark_in       = 1'b0;
                  need_extra_in = 1'b0;
                  state_in      = S_PAD;
               end
            end
         end
         S_PAD: begin
            push = 1'b1;
            if (!mark_ff) begin
               push_byte     = shabs_pkg::PadMarker;
               mark_in       = 1'b1;
               need_extra_in = (fill_ff[5:3] == 3'b111);
            end else if (fill_ff[5:3] == 3'b111 && !need_extra_ff) begin
               push_byte = bit_len[{~fill_ff[2:0], 3'b000} +: 8];
            end
            last_block_in = mark_ff && !need_extra_ff;
         end
         S_ROUND: begin
            wv_in = wv_next;
            for (int i = 0; i < shabs_pkg::SchedLen - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[shabs_pkg::SchedLen-1] = w_new;
            round_in = round_ff + 6'd1;
            if (round_ff == LastRound) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            chain_in[0] = chain_ff[0] + wv_ff.a;
            chain_in[1] = chain_ff[1] + wv_ff.b;
            chain_in[2] = chain_ff[2] + wv_ff.c;
            chain_in[3] = chain_ff[3] + wv_ff.d;
            chain_in[4] = chain_ff[4] + wv_ff.e;
            chain_in[5] = chain_ff[5] + wv_ff.f;
            chain_in[6] = chain_ff[6] + wv_ff.g;
            chain_in[7] = chain_ff[7] + wv_ff.h;
            need_extra_in = 1'b0;
            word_in       = '0;
            if (last_block_ff) begin
               state_in = S_EMIT;
            end else if (pad_active_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (rsp_fire) begin
               for (int i = 0; i < shabs_pkg::NumWords - 1; i++) begin
                  chain_in[i] = chain_ff[i+1];
               end
               chain_in[shabs_pkg::NumWords-1] = chain_ff[0];
               word_in = word_ff + 3'd1;
               if (word_ff == LastWord) begin
                  chain_in      = shabs_pkg::InitHash;
                  count_in      = '0;
                  pad_active_in = 1'b0;
                  mark_in       = 1'b0;
                  last_block_in = 1'b0;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // byte path: the window shifts left by one byte, byte 0 ends at the top of W0
      if (push) begin
         for (int i = 0; i < shabs_pkg::SchedLen - 1; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[shabs_pkg::SchedLen-1] = {win_ff[shabs_pkg::SchedLen-1][23:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff == LastByte) begin
            wv_in    = {chain_ff[0], chain_ff[1], chain_ff[2], chain_ff[3],
                        chain_ff[4], chain_ff[5], chain_ff[6], chain_ff[7]};
            round_in = '0;
            state_in = S_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         round_ff      <= '0;
         word_ff       <= '0;
         count_ff      <= '0;
         pad_active_ff <= 1'b0;
         mark_ff       <= 1'b0;
         need_extra_ff <= 1'b0;
         last_block_ff <= 1'b0;
         chain_ff      <= shabs_pkg::InitHash;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         round_ff      <= round_in;
         word_ff       <= word_in;
         count_ff      <= count_in;
         pad_active_ff <= pad_active_in;
         mark_ff       <= mark_in;
         need_extra_ff <= need_extra_in;
         last_block_ff <= last_block_in;
         chain_ff      <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      wv_ff  <= wv_in;
   end

   // --- checks -------------------------------------------------------------
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while digest is out");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && round_ff == LastRound) |=> (state_ff == S_FOLD))
      else $error("compression did not end after the last round");

   a_block_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (fill_ff == '0))
      else $error("compression running on a partial block");

   a_digest_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> (state_ff == S_IDLE && count_ff == '0 && fill_ff == '0))
      else $error("state not restored after the digest");

endmodule
`default_nettype wire

// ===== tb/sha256_digest_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_scoreboard_pkg
// Software SHA-256 over the accepted requests and the digest word checker.
// ----------------------------------------------------------------------------
package sha256_digest_scoreboard_pkg;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  number;
      logic        last;
   } digest_word_type;

   // own copy of the FIPS 180-4 constants, kept apart from the design package
   localparam logic [31:0] StartHash [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundConst [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   class digest_scoreboard;
      logic [31:0]     chain [8];
      logic [7:0]      block_buf [64];
      logic [63:0]     byte_count;
      digest_word_type expected_words [$];
      int              failures;

      function new();
         for (int i = 0; i < 8; i++) chain[i] = StartHash[i];
         for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
         byte_count = 64'd0;
         failures   = 0;
      endfunction

      function logic [31:0] rotr(logic [31:0] v, int n);
         return (v >> n) | (v << (32 - n));
      endfunction

      function void compress_block();
         logic [31:0] w [64];
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
         for (int t = 0; t < 16; t++)
            w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
         for (int t = 16; t < 64; t++)
            w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
         for (int t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + RoundConst[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
         chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      endfunction

      // one accepted request: take the byte, and on end of message pad,
      // finish and queue the eight digest words
      function void absorb_request(logic [7:0] data, logic present, logic finish);
         int unsigned     pos;
         logic [63:0]     bit_len;
         digest_word_type dw;
         if (present) begin
            pos = byte_count[5:0];
            block_buf[pos] = data;
            byte_count += 64'd1;
            if (pos == 63) compress_block();
         end
         if (!finish) return;
         pos = byte_count[5:0];
         block_buf[pos] = 8'h80;
         for (int i = pos + 1; i < 64; i++) block_buf[i] = 8'h00;
         // no room left for the length: extra block
         if (pos >= 56) begin
            compress_block();
            for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
         end
         bit_len = byte_count << 3;
         for (int i = 0; i < 8; i++) block_buf[56+i] = bit_len[8*(7-i) +: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            dw.word   = chain[i];
            dw.number = i[2:0];
            dw.last   = (i == 7);
            expected_words.insert(expected_words.size(), dw);
         end
         for (int i = 0; i < 8; i++) chain[i] = StartHash[i];
         byte_count = 64'd0;
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_word(logic [31:0] word, logic [2:0] number, logic last);
         digest_word_type want;
         if (expected_words.size() == 0) begin
            note_failure($sformatf("digest word %h (number %0d, last %b) with none expected",
                                   word, number, last));
            return;
         end
         want = expected_words.pop_front();
         if (word !== want.word || number !== want.number || last !== want.last)
            note_failure($sformatf("expected %h number %0d last %b, got %h number %0d last %b",
                                   want.word, want.number, want.last, word, number, last));
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

endpackage

// ===== tb/sha256_byte_stream_hasher_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit_tb
// Streams messages into the hasher, predicts each digest in software and
// checks every digest word as it leaves, under random idling on both sides.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit_tb;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tuser  = 1'b0;    // [0] byte_present
   logic        req_tlast  = 1'b0;    // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] digest_word
   logic [2:0]  rsp_tuser;            // [2:0] word_number
   logic        rsp_tlast;            // last_word

   bit                                             steady = 1'b0;   // high: neither side idles
   sha256_digest_scoreboard_pkg::digest_scoreboard sb;

   sha256_byte_stream_hasher_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // accepted requests feed the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.absorb_request(req_tdata, req_tuser, req_tlast);
   end

   // check each accepted digest word, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= steady || ($urandom_range(0, 99) >= 22);
   end

   // valid stays high from one request to the next unless a gap is chosen
   task automatic send_request(input logic [7:0] data, input logic present,
                               input logic finish);
      if (!steady && $urandom_range(0, 99) < 22) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 22);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= present;
      req_tlast  <= finish;
      do @(posedge clock); while (!req_tready);
   endtask

   // random bytes with the odd byteless request mixed in; the end mark rides
   // either on the last byte or on a request of its own
   task automatic send_message(input int len);
      bit close_on_byte;
      close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_request(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
      end
      if (!close_on_byte) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      int items;
      int msg;
      int len;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty message, data byte must be ignored
      send_request(8'hff, 1'b0, 1'b1);
      // request with neither byte nor end: no effect
      send_request(8'ha5, 1'b0, 1'b0);
      // "abc", end mark on the last byte
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b1);
      // extremes with an ignored byte in between, end on a byteless request
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'h5a, 1'b0, 1'b0);
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'h3c, 1'b0, 1'b1);
      // a byte equal to the pad marker, then two empty messages back to back
      send_request(8'h80, 1'b1, 1'b1);
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'h7e, 1'b0, 1'b1);

      // random messages; one long enough to push the length into an extra block
      // and, while the item budget lasts, one exactly a full block and a no-idle stretch
      items = 0;
      msg   = 0;
      while (items < 120) begin
         steady = (msg >= 3 && msg < 7);
         if (msg == 2)
            len = $urandom_range(56, 63);
         else if (msg == 5)
            len = 64;
         else if ($urandom_range(0, 3) == 0)
            len = $urandom_range(9, 30);
         else
            len = $urandom_range(0, 6);
         send_message(len);
         items += len + 1;
         msg++;
      end
      steady = 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      // catch any stray word after the last digest
      repeat (300) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("sha256_byte_stream_hasher_unit_tb passed");
      else
         $display("sha256_byte_stream_hasher_unit_tb failed");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("sha256_byte_stream_hasher_unit_tb failed");
      $finish;
   end

endmodule
